>>> src/wcc_pkg.sv
// ----------------------------------------------------------------------------
// wcc_pkg
// shared codes and the node store word for the component labeller
// ----------------------------------------------------------------------------
package wcc_pkg;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_LABEL = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic       seen;
    logic [7:0] label;
  } node_word_t;

  typedef struct packed {
    logic                  wr;
    logic                  rd;
    wcc_pkg::node_word_t   wdata;
  } node_cmd_t;

endpackage

>>> src/weakly_connected_components.sv
// ----------------------------------------------------------------------------
// weakly_connected_components
// breadth-first labelling of the connected components of an undirected graph
// ----------------------------------------------------------------------------
//  channel | signals                                      | direction
//  in      | in_valid in_ready op node_a node_b            | request in
//  out     | out_valid out_ready comp_label               | result out
//          |   component_count status                     |
//  cfg     | cfg_valid cfg_ready cfg_data (node_count)     | register write
//
// add edge and clear edges act on the edge store; a good query reads the
// node memory once. a labelling run clears the nodes, scans each node,
// searches once per component, and per dequeued node reads every stored
// edge and the far node of each live edge that touches it; the edge store
// read loop sets its length.
// after reset a clearing pass writes all MAX_NODES node entries, one a cycle,
// with in_ready low. a waiting result does not block the next request; a new
// result waits in its final state until the output register is free.
module weakly_connected_components #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] node_a,
  input  logic [7:0] node_b,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] comp_label,
  output logic [8:0] component_count,
  output logic [1:0] status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int FW  = $clog2(MAX_EDGES + 1);
  localparam logic [8:0]     NMAX9 = (MAX_NODES > 511) ? 9'd511 : 9'(MAX_NODES);
  localparam logic [NAW-1:0] NLAST = NAW'(MAX_NODES - 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_QWT, S_WIPE, S_SCAN, S_SCAN_WT, S_POP, S_POP_WT,
    S_EDGE, S_EDGE_WT, S_NODE_WT, S_DONE
  } state_t;

  state_t              state;
  logic [8:0]          node_count;
  logic [8:0]          n_eff;
  logic [NAW-1:0]      init_idx;
  logic [8:0]          s;
  logic [8:0]          comp;
  logic [8:0]          components;
  logic [8:0]          head;
  logic [8:0]          tail;
  logic [8:0]          v;
  logic [8:0]          w;
  logic [FW-1:0]       e;
  logic [7:0]          res_id;
  logic [1:0]          res_status;

  logic                edge_push;
  logic                edge_clear;
  logic                edge_rd;
  logic [15:0]         edge_rdata;
  logic [FW-1:0]       fill;
  logic                full;

  wcc_pkg::node_cmd_t  node_cmd;
  logic [NAW-1:0]      node_addr;
  wcc_pkg::node_word_t node_rdata;

  logic                q_wr;
  logic                q_rd;
  logic [NAW-1:0]      q_addr;
  logic [8:0]          q_wdata;
  logic [8:0]          q_rdata;

  logic                accept;
  logic                slot_free;
  logic [8:0]          ea;
  logic [8:0]          eb;
  logic                edge_live;
  logic                edge_hit;
  logic [8:0]          edge_other;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    if (node_count == 9'd0) begin
      n_eff = 9'd1;
    end else if (32'(node_count) > MAX_NODES) begin
      n_eff = NMAX9;
    end else begin
      n_eff = node_count;
    end
  end

  // stale edges (an endpoint at or past the count) take no part in a run
  assign ea         = {1'b0, edge_rdata[15:8]};
  assign eb         = {1'b0, edge_rdata[7:0]};
  assign edge_live  = (ea < n_eff) && (eb < n_eff);
  assign edge_hit   = edge_live && ((ea == v) || (eb == v));
  assign edge_other = (ea == v) ? eb : ea;

  always_comb begin
    edge_push  = 1'b0;
    edge_clear = 1'b0;
    edge_rd    = (state == S_EDGE) && (e != fill);
    node_cmd   = '0;
    node_addr  = NAW'(s);
    q_wr       = 1'b0;
    q_rd       = 1'b0;
    q_addr     = NAW'(head);
    q_wdata    = w;
    case (state)
      S_INIT: begin
        node_cmd.wr = 1'b1;
        node_addr   = init_idx;
      end
      S_IDLE: begin
        node_addr = NAW'(node_a);
        if (accept) begin
          case (op)
            wcc_pkg::OP_ADD: begin
              edge_push = ({1'b0, node_a} < n_eff) && ({1'b0, node_b} < n_eff) && !full;
            end
            wcc_pkg::OP_CLEAR: edge_clear = 1'b1;
            wcc_pkg::OP_QUERY: node_cmd.rd = ({1'b0, node_a} < n_eff);
            default: ;
          endcase
        end
      end
      S_WIPE: node_cmd.wr = 1'b1;
      S_SCAN: node_cmd.rd = (s != n_eff);
      S_SCAN_WT: begin
        if (!node_rdata.seen) begin
          node_cmd.wr          = 1'b1;
          node_cmd.wdata.seen  = 1'b1;
          node_cmd.wdata.label = comp[7:0];
          q_wr                 = 1'b1;
          q_addr               = '0;
          q_wdata              = s;
        end
      end
      S_POP: q_rd = (head != tail);
      S_EDGE_WT: begin
        node_cmd.rd = edge_hit;
        node_addr   = NAW'(edge_other);
      end
      S_NODE_WT: begin
        node_addr = NAW'(w);
        if (!node_rdata.seen) begin
          node_cmd.wr          = 1'b1;
          node_cmd.wdata.seen  = 1'b1;
          node_cmd.wdata.label = comp[7:0];
          q_wr                 = 1'b1;
          q_addr               = NAW'(tail);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      init_idx   <= '0;
      node_count <= 9'd256;
      components <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_idx <= init_idx + 1'b1;
          if (init_idx == NLAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          res_id     <= '0;
          res_status <= wcc_pkg::ST_OK;
          s          <= '0;
          if (accept) begin
            state <= S_DONE;
            case (op)
              wcc_pkg::OP_ADD: begin
                if (({1'b0, node_a} >= n_eff) || ({1'b0, node_b} >= n_eff)) begin
                  res_status <= wcc_pkg::ST_RANGE;
                end else if (full) begin
                  res_status <= wcc_pkg::ST_FULL;
                end
              end
              wcc_pkg::OP_LABEL: state <= S_WIPE;
              wcc_pkg::OP_QUERY: begin
                if ({1'b0, node_a} >= n_eff) begin
                  res_status <= wcc_pkg::ST_RANGE;
                end else begin
                  state <= S_QWT;
                end
              end
              default: ;
            endcase
          end
        end
        S_QWT: begin
          res_id <= node_rdata.label;
          state  <= S_DONE;
        end
        // every node below the count is relabelled, so clear them all first
        S_WIPE: begin
          if (s == n_eff - 9'd1) begin
            s     <= '0;
            comp  <= '0;
            state <= S_SCAN;
          end else begin
            s <= s + 9'd1;
          end
        end
        S_SCAN: begin
          if (s == n_eff) begin
            components <= comp;
            state      <= S_DONE;
          end else begin
            state <= S_SCAN_WT;
          end
        end
        S_SCAN_WT: begin
          if (node_rdata.seen) begin
            s     <= s + 9'd1;
            state <= S_SCAN;
          end else begin
            head  <= '0;
            tail  <= 9'd1;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (head == tail) begin
            comp  <= comp + 9'd1;
            s     <= s + 9'd1;
            state <= S_SCAN;
          end else begin
            head  <= head + 9'd1;
            state <= S_POP_WT;
          end
        end
        S_POP_WT: begin
          v     <= q_rdata;
          e     <= '0;
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (e == fill) begin
            state <= S_POP;
          end else begin
            e     <= e + 1'b1;
            state <= S_EDGE_WT;
          end
        end
        S_EDGE_WT: begin
          w     <= edge_other;
          state <= edge_hit ? S_NODE_WT : S_EDGE;
        end
        S_NODE_WT: begin
          if (!node_rdata.seen) begin
            tail <= tail + 9'd1;
          end
          state <= S_EDGE;
        end
        S_DONE: begin
          if (slot_free) begin
            out_valid       <= 1'b1;
            comp_label      <= res_id;
            component_count <= components;
            status          <= res_status;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  wcc_edge_store #(
    .MAX_EDGES (MAX_EDGES),
    .EAW       (EAW),
    .FW        (FW)
  ) u_edges (
    .clk   (clk),
    .rst   (rst),
    .push  (edge_push),
    .clear (edge_clear),
    .wdata ({node_a, node_b}),
    .rd    (edge_rd),
    .raddr (e),
    .rdata (edge_rdata),
    .fill  (fill),
    .full  (full)
  );

  wcc_node_store #(
    .MAX_NODES (MAX_NODES),
    .NAW       (NAW)
  ) u_nodes (
    .clk   (clk),
    .cmd   (node_cmd),
    .addr  (node_addr),
    .rdata (node_rdata)
  );

  wcc_queue #(
    .MAX_NODES (MAX_NODES),
    .NAW       (NAW)
  ) u_queue (
    .clk   (clk),
    .wr    (q_wr),
    .rd    (q_rd),
    .addr  (q_addr),
    .wdata (q_wdata),
    .rdata (q_rdata)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_EDGES))
    else $error("edge fill past store depth");

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP || state == S_EDGE) |-> (head <= tail) && (tail <= n_eff))
    else $error("search queue pointers out of order");

  a_bad_query_id: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status != wcc_pkg::ST_OK) |-> (res_id == 8'd0))
    else $error("rejected request carries a label");

  a_edge_no_store: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(fill))
    else $error("edge store changed during a run");
`endif

endmodule

>>> src/wcc_edge_store.sv
// ----------------------------------------------------------------------------
// wcc_edge_store
// edge memory with its fill count; endpoints packed as {a, b}
// ----------------------------------------------------------------------------
module wcc_edge_store #(
  parameter int MAX_EDGES = 1024,
  parameter int EAW       = 10,
  parameter int FW        = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic          clear,
  input  logic [15:0]   wdata,
  input  logic          rd,
  input  logic [FW-1:0] raddr,
  output logic [15:0]   rdata,
  output logic [FW-1:0] fill,
  output logic          full
);

  logic [15:0] mem [MAX_EDGES];

  assign full = (fill == FW'(MAX_EDGES));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear) begin
      fill <= '0;
    end else if (push) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[fill[EAW-1:0]] <= wdata;
    end
    if (rd) begin
      rdata <= mem[raddr[EAW-1:0]];
    end
  end

endmodule

>>> src/wcc_node_store.sv
// ----------------------------------------------------------------------------
// wcc_node_store
// per-node seen mark and component label, one port
// ----------------------------------------------------------------------------
module wcc_node_store #(
  parameter int MAX_NODES = 256,
  parameter int NAW       = 8
) (
  input  logic                clk,
  input  wcc_pkg::node_cmd_t  cmd,
  input  logic [NAW-1:0]      addr,
  output wcc_pkg::node_word_t rdata
);

  wcc_pkg::node_word_t mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> src/wcc_queue.sv
// ----------------------------------------------------------------------------
// wcc_queue
// search queue memory, written at the tail and read at the head
// ----------------------------------------------------------------------------
module wcc_queue #(
  parameter int MAX_NODES = 256,
  parameter int NAW       = 8
) (
  input  logic           clk,
  input  logic           wr,
  input  logic           rd,
  input  logic [NAW-1:0] addr,
  input  logic [8:0]     wdata,
  output logic [8:0]     rdata
);

  logic [8:0] mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[addr] <= wdata;
    end
    if (rd) begin
      rdata <= mem[addr];
    end
  end

endmodule
